// File: rtl/bsfr_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap store package
// Shared payload types, operation codes and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfr_pkg;

    localparam int MAX_BITS_DEF = 4096;

    localparam logic [7:0] BYTE_MASK = 8'hff;
    localparam logic [2:0] BIT_SEL   = 3'd7;

    localparam logic [2:0] KIND_READ  = 3'd0;
    localparam logic [2:0] KIND_WRITE = 3'd1;
    localparam logic [2:0] KIND_FILL  = 3'd2;
    localparam logic [2:0] KIND_ROTR  = 3'd3;
    localparam logic [2:0] KIND_ROTL  = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] bit_index;
        logic [12:0] range_length;
        logic [11:0] shift_amount;
        logic        bit_value;
    } in_item_t;

    typedef struct packed {
        logic read_bit;
        logic status;
    } out_item_t;

endpackage

`default_nettype wire

// File: rtl/bitmap_store_fill_rotate.sv
// ----------------------------------------------------------------------------
// Bitmap store with range fill and rotation
// Bit-addressed bitmap held in a byte RAM, most significant bit first.
// ----------------------------------------------------------------------------
// Usage: an operation arrives on in_valid/in_ready as one in_item_t and gives
// exactly one out_item_t on out_valid/out_ready. cfg_valid/cfg_ready writes
// bitmap_size and is always ready; write it only while the block is idle.
// One operation is worked on at a time, through read-modify-write of the
// store RAM, whose single read port sets the steps below:
//   read or write bit: read the byte, then take the bit or write it back;
//   fill: read and write back each byte touched, edge bytes under a mask;
//   rotate: copy each byte of the range into the snapshot RAM, then, bit by
//   bit, read-modify-write the target byte from the snapshot.
// After reset a clearing pass writes zero to every byte, and in_ready stays
// low meanwhile. The result waits in an output register, so a new operation
// is taken while the receiver stalls; the following result then waits until
// the register has been taken.
// Rejected operations (out of range, bad rotation, unknown kind) and empty
// fills go straight from idle to the done state and leave the store unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_store_fill_rotate #(
    parameter int MAX_BITS = bsfr_pkg::MAX_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire bsfr_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output bsfr_pkg::out_item_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [12:0]         cfg_data
);

    import bsfr_pkg::*;

    localparam int DEPTH = (MAX_BITS + 7) / 8;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_WR   = 3'd3;
    localparam logic [2:0] ST_CPR  = 3'd4;
    localparam logic [2:0] ST_CPW  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [12:0]   size_reg;
    logic [2:0]    kind_reg, kind_next;
    logic [11:0]   start_reg, start_next;
    logic [12:0]   len_reg, len_next;
    logic [12:0]   i_reg, i_next;
    logic [12:0]   j_reg, j_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] first_reg, first_next;
    logic [AW-1:0] last_reg, last_next;
    logic [2:0]    foff_reg, foff_next;
    logic [2:0]    loff_reg, loff_next;
    logic          val_reg, val_next;
    logic          rd_reg, rd_next;
    logic          st_reg, st_next;
    logic          out_valid_reg;
    out_item_t     out_data_reg;

    logic [16:0]   eff_size;
    logic [16:0]   idx_ext, end_ext;
    logic          idx_ok, rng_ok, rot_ok;
    logic [13:0]   last_bit;
    logic          right;
    logic [13:0]   src_pos, dst_pos;
    logic [7:0]    mask, head_m, tail_m;
    logic          wbit;
    logic          out_load;

    logic          st_we, sn_we;
    logic [AW-1:0] st_waddr, st_raddr, sn_waddr, sn_raddr;
    logic [7:0]    st_wdata, st_rdata, sn_rdata;

    bsfr_ram #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    bsfr_ram #(.DEPTH(DEPTH), .AW(AW)) u_snap (
        .clk   (clk),
        .we    (sn_we),
        .waddr (sn_waddr),
        .wdata (st_rdata),
        .raddr (sn_raddr),
        .rdata (sn_rdata)
    );

    assign eff_size = (32'(size_reg) > 32'(MAX_BITS)) ? 17'(MAX_BITS) : {4'b0, size_reg};
    assign idx_ext  = {5'b0, in_data.bit_index};
    assign end_ext  = idx_ext + {4'b0, in_data.range_length};
    assign idx_ok   = idx_ext < eff_size;
    assign rng_ok   = end_ext <= eff_size;
    assign rot_ok   = (in_data.shift_amount != 12'd0)
                    && ({1'b0, in_data.shift_amount} < in_data.range_length) && rng_ok;
    assign last_bit = {2'b0, in_data.bit_index} + {1'b0, in_data.range_length} - 14'd1;

    assign right   = (kind_reg == KIND_ROTR);
    assign src_pos = {2'b0, start_reg} + {1'b0, right ? i_reg : j_reg};
    assign dst_pos = {2'b0, start_reg} + {1'b0, right ? j_reg : i_reg};

    assign head_m = (cur_reg == first_reg) ? (BYTE_MASK >> foff_reg) : BYTE_MASK;
    assign tail_m = (cur_reg == last_reg) ? (BYTE_MASK << (BIT_SEL - loff_reg)) : BYTE_MASK;

    always_comb
    begin
        if (kind_reg == KIND_ROTR || kind_reg == KIND_ROTL)
        begin
            mask = 8'h80 >> dst_pos[2:0];
            wbit = sn_rdata[BIT_SEL - src_pos[2:0]];
        end
        else
        begin
            mask = head_m & tail_m;
            wbit = val_reg;
        end
    end

    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = cur_reg;
        st_wdata = wbit ? (st_rdata | mask) : (st_rdata & ~mask);
        st_raddr = cur_reg;
        sn_we    = (state_reg == ST_CPW);
        sn_waddr = cur_reg;
        sn_raddr = AW'(src_pos[13:3]);
        if (state_reg == ST_CLR)
        begin
            st_we    = 1'b1;
            st_wdata = 8'h00;
        end
        else if (state_reg == ST_WR && kind_reg != KIND_READ)
        begin
            st_we = 1'b1;
        end
        if (kind_reg == KIND_ROTR || kind_reg == KIND_ROTL)
        begin
            if (state_reg == ST_RD || state_reg == ST_WR)
            begin
                st_raddr = AW'(dst_pos[13:3]);
                st_waddr = AW'(dst_pos[13:3]);
            end
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        start_next = start_reg;
        len_next   = len_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cur_next   = cur_reg;
        first_next = first_reg;
        last_next  = last_reg;
        foff_next  = foff_reg;
        loff_next  = loff_reg;
        val_next   = val_reg;
        rd_next    = rd_reg;
        st_next    = st_reg;
        unique case (state_reg)
            ST_CLR:
            begin
                cur_next = cur_reg + AW'(1);
                if (cur_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = in_data.kind;
                    start_next = in_data.bit_index;
                    len_next   = in_data.range_length;
                    val_next   = in_data.bit_value;
                    i_next     = 13'd0;
                    j_next     = {1'b0, in_data.shift_amount};
                    foff_next  = in_data.bit_index[2:0];
                    loff_next  = in_data.bit_index[2:0];
                    cur_next   = AW'(in_data.bit_index[11:3]);
                    first_next = AW'(in_data.bit_index[11:3]);
                    last_next  = AW'(in_data.bit_index[11:3]);
                    rd_next    = 1'b0;
                    st_next    = 1'b1;
                    state_next = ST_DONE;
                    unique case (in_data.kind)
                        KIND_READ, KIND_WRITE:
                        begin
                            if (idx_ok)
                            begin
                                st_next    = 1'b0;
                                state_next = ST_RD;
                            end
                        end
                        KIND_FILL:
                        begin
                            if (rng_ok)
                            begin
                                st_next   = 1'b0;
                                loff_next = last_bit[2:0];
                                last_next = AW'(last_bit[13:3]);
                                if (in_data.range_length != 13'd0)
                                begin
                                    state_next = ST_RD;
                                end
                            end
                        end
                        KIND_ROTR, KIND_ROTL:
                        begin
                            if (rot_ok)
                            begin
                                st_next    = 1'b0;
                                last_next  = AW'(last_bit[13:3]);
                                state_next = ST_CPR;
                            end
                        end
                        default:
                        begin
                            st_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_CPR:
            begin
                state_next = ST_CPW;
            end
            ST_CPW:
            begin
                // The range is copied byte by byte before any bit moves.
                if (cur_reg == last_reg)
                begin
                    state_next = ST_RD;
                end
                else
                begin
                    cur_next   = cur_reg + AW'(1);
                    state_next = ST_CPR;
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                state_next = ST_DONE;
                if (kind_reg == KIND_READ)
                begin
                    rd_next = st_rdata[BIT_SEL - foff_reg];
                end
                else if (kind_reg == KIND_ROTR || kind_reg == KIND_ROTL)
                begin
                    if (i_reg != len_reg - 13'd1)
                    begin
                        i_next     = i_reg + 13'd1;
                        j_next     = (j_reg + 13'd1 == len_reg) ? 13'd0 : j_reg + 13'd1;
                        state_next = ST_RD;
                    end
                end
                else if (cur_reg != last_reg)
                begin
                    cur_next   = cur_reg + AW'(1);
                    state_next = ST_RD;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            cur_reg       <= '0;
            size_reg      <= 13'(MAX_BITS > 8191 ? 8191 : MAX_BITS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            if (cfg_valid)
            begin
                size_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        start_reg <= start_next;
        len_reg   <= len_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        foff_reg  <= foff_next;
        loff_reg  <= loff_next;
        val_reg   <= val_next;
        rd_reg    <= rd_next;
        st_reg    <= st_next;
        if (out_load)
        begin
            out_data_reg.read_bit <= rd_reg;
            out_data_reg.status   <= st_reg;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bsfr_ram.sv
// ----------------------------------------------------------------------------
// Byte RAM
// Simple dual-port byte memory, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfr_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Bitmap store testbench
// Directed table then constrained-random operations on the bitmap store.
// Every result is checked in order, against the row's expected result where
// a directed row gives one and else against a byte-level model of the store,
// with bitmap_size changed between phases while the block is idle.
`default_nettype none

module tb_top;
    import bsfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES = (MAX_BITS_DEF + 7) / 8;
    localparam logic [2:0] KIND_BAD5 = 3'd5;
    localparam logic [2:0] KIND_BAD6 = 3'd6;
    localparam logic [2:0] KIND_BAD7 = 3'd7;
    localparam logic ST_DONE = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    typedef struct packed {
        in_item_t  op;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [12:0] cfg_data = '0;

    logic [7:0]  bitmap_mirror [STORE_BYTES];
    logic [7:0]  rotate_copy [STORE_BYTES];
    logic [12:0] size_reg;
    out_item_t   pending_results [$];
    int          errors = 0;
    bit          quiet = 1'b0;
    int          stall_left = 0;
    dir_row_t    dir_rows [$];

    bitmap_store_fill_rotate dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int size_now();
        return (size_reg > MAX_BITS_DEF) ? MAX_BITS_DEF : int'(size_reg);
    endfunction

    function automatic logic get_bit(bit from_copy, int n);
        logic [7:0] b;
        b = from_copy ? rotate_copy[n >> 3] : bitmap_mirror[n >> 3];
        return b[BIT_SEL - n[2:0]];
    endfunction

    function automatic void put_bit(int n, logic v);
        bitmap_mirror[n >> 3][BIT_SEL - n[2:0]] = v;
    endfunction

    function automatic void add_row(dir_row_t row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void expect_result(out_item_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Applies one operation to the mirror and returns the result it gives.
    function automatic out_item_t apply_op(in_item_t op);
        out_item_t  r;
        int         idx;
        int         len;
        int         amt;
        int         j;
        idx = int'(op.bit_index);
        len = int'(op.range_length);
        amt = int'(op.shift_amount);
        r.read_bit = 1'b0;
        r.status = ST_REJECT;
        case (op.kind)
            KIND_READ:
                if (idx < size_now())
                begin
                    r.read_bit = get_bit(1'b0, idx);
                    r.status = ST_DONE;
                end
            KIND_WRITE:
                if (idx < size_now())
                begin
                    put_bit(idx, op.bit_value);
                    r.status = ST_DONE;
                end
            KIND_FILL:
                if (idx + len <= size_now())
                begin
                    // Bitwise fill gives the same bytes as edge masks plus whole bytes.
                    for (int i = 0; i < len; i++)
                        put_bit(idx + i, op.bit_value);
                    r.status = ST_DONE;
                end
            KIND_ROTR, KIND_ROTL:
                if (amt > 0 && amt < len && idx + len <= size_now())
                begin
                    for (int i = 0; i < STORE_BYTES; i++)
                        rotate_copy[i] = bitmap_mirror[i];
                    for (int i = 0; i < len; i++)
                    begin
                        j = i + amt;
                        if (j >= len)
                            j -= len;
                        if (op.kind == KIND_ROTR)
                            put_bit(idx + j, get_bit(1'b1, idx + i));
                        else
                            put_bit(idx + i, get_bit(1'b1, idx + j));
                    end
                    r.status = ST_DONE;
                end
            default:
                r.status = ST_REJECT;
        endcase
        return r;
    endfunction

    function automatic in_item_t mk_op(logic [2:0] k, int idx, int len, int amt, logic v);
        in_item_t op;
        op.kind = k;
        op.bit_index = idx[11:0];
        op.range_length = len[12:0];
        op.shift_amount = amt[11:0];
        op.bit_value = v;
        return op;
    endfunction

    function automatic in_item_t random_op();
        in_item_t op;
        int       s;
        int       len;
        int       top;
        s = size_now();
        if ($urandom_range(0, 99) < 15 || s == 0)
        begin
            op.kind = 3'($urandom);
            op.bit_index = 12'($urandom);
            op.range_length = 13'($urandom);
            op.shift_amount = 12'($urandom);
            op.bit_value = 1'($urandom);
            return op;
        end
        op.kind = 3'($urandom_range(0, 4));
        op.bit_value = 1'($urandom);
        top = (s < 64) ? s : 64;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, s) : $urandom_range(0, top);
        op.range_length = len[12:0];
        op.bit_index = 12'($urandom_range(0, s - len));
        op.shift_amount = (len >= 2) ? 12'($urandom_range(1, len - 1)) : '0;
        if (op.kind == KIND_READ || op.kind == KIND_WRITE)
            op.bit_index = 12'($urandom_range(0, s - 1));
        return op;
    endfunction

    task automatic send_op(in_item_t op, out_item_t typed_want, bit typed);
        out_item_t predicted;
        int        gap;
        gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= op;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = apply_op(op);
        expect_result(typed ? typed_want : predicted);
    endtask

    task automatic write_size(logic [12:0] value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        size_reg = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int count);
        repeat (count)
            send_op(random_op(), '0, 1'b0);
    endtask

    // Receiver side: random stall bursts, none in the final phase.
    always @(posedge clk)
    begin
        if (quiet)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                stall_left <= $urandom_range(1, 11);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected: %b", out_data);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.read_bit !== want.read_bit)
                begin
                    $error("read_bit expected %0d actual %0d", want.read_bit, out_data.read_bit);
                    errors++;
                end
                if (out_data.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, out_data.status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < STORE_BYTES; i++)
        begin
            bitmap_mirror[i] = '0;
            rotate_copy[i] = '0;
        end
        size_reg = 13'(MAX_BITS_DEF);

        add_row('{mk_op(KIND_READ, 0, 0, 0, 1'b0), 1'b1, '{1'b0, ST_DONE}});
        add_row('{mk_op(KIND_READ, 4095, 8191, 4095, 1'b1), 1'b1, '{1'b0, ST_DONE}});
        add_row('{mk_op(KIND_WRITE, 0, 0, 0, 1'b1), 1'b1, '{1'b0, ST_DONE}});
        add_row('{mk_op(KIND_WRITE, 4095, 0, 0, 1'b1), 1'b1, '{1'b0, ST_DONE}});
        add_row('{mk_op(KIND_READ, 4095, 0, 0, 1'b0), 1'b1, '{1'b1, ST_DONE}});
        add_row('{mk_op(KIND_FILL, 3, 18, 0, 1'b1), 1'b0, '0});
        add_row('{mk_op(KIND_FILL, 100, 0, 0, 1'b1), 1'b0, '0});
        add_row('{mk_op(KIND_FILL, 4090, 7, 0, 1'b1), 1'b1, '{1'b0, ST_REJECT}});
        add_row('{mk_op(KIND_FILL, 0, 4096, 0, 1'b1), 1'b1, '{1'b0, ST_DONE}});
        add_row('{mk_op(KIND_READ, 2048, 0, 0, 1'b0), 1'b1, '{1'b1, ST_DONE}});
        add_row('{mk_op(KIND_FILL, 9, 3000, 0, 1'b0), 1'b0, '0});
        add_row('{mk_op(KIND_ROTR, 0, 16, 3, 1'b0), 1'b0, '0});
        add_row('{mk_op(KIND_ROTL, 5, 9, 8, 1'b0), 1'b0, '0});
        add_row('{mk_op(KIND_ROTR, 0, 16, 0, 1'b0), 1'b1, '{1'b0, ST_REJECT}});
        add_row('{mk_op(KIND_ROTL, 0, 16, 16, 1'b0), 1'b1, '{1'b0, ST_REJECT}});
        add_row('{mk_op(KIND_ROTR, 4000, 97, 5, 1'b0), 1'b1, '{1'b0, ST_REJECT}});
        add_row('{mk_op(KIND_ROTL, 0, 4096, 4095, 1'b0), 1'b0, '0});
        add_row('{mk_op(KIND_BAD5, 0, 1, 0, 1'b1), 1'b1, '{1'b0, ST_REJECT}});
        add_row('{mk_op(KIND_BAD6, 0, 1, 0, 1'b1), 1'b1, '{1'b0, ST_REJECT}});
        add_row('{mk_op(KIND_BAD7, 4095, 8191, 4095, 1'b1), 1'b1, '{1'b0, ST_REJECT}});
        add_row('{mk_op(KIND_READ, 3, 0, 0, 1'b0), 1'b0, '0});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_op(dir_rows[i].op, dir_rows[i].want, dir_rows[i].typed);
        run_random(280);

        // Sizes above the bitmap act as the full bitmap.
        write_size(13'h1fff);
        run_random(100);
        write_size(13'd1);
        run_random(60);
        write_size(13'd0);
        run_random(40);
        write_size(13'($urandom_range(2, 4095)));
        run_random(150);
        write_size(13'($urandom_range(9, 200)));
        run_random(150);
        write_size(13'(MAX_BITS_DEF));
        quiet = 1'b1;
        run_random(150);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/bsfr_pkg.sv
rtl/bsfr_ram.sv
rtl/bitmap_store_fill_rotate.sv
tb/sv/tb_top.sv
